>>> design/ytp_pkg.sv
// Shared types and constants for the yaw trapezoid profile controller.
// Used by ytp_math, the top level and the port checker.
package ytp_pkg;

    // Operation codes of the shared serial arithmetic unit
    typedef enum logic [1:0] {
        MATH_MUL  = 2'd0,
        MATH_DIV  = 2'd1,
        MATH_SQRT = 2'd2
    } math_op_t;

    // Request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic     start;
        math_op_t op;
    } math_req_t;

    localparam int OPA_W = 48;
    localparam int OPB_W = 24;

    localparam logic [OPB_W-1:0] KP_Q16      = 24'd410139;
    localparam logic [OPB_W-1:0] KV_Q16      = 24'd546852;
    localparam logic [OPB_W-1:0] ACCEL_K     = 24'd960000;
    localparam logic [OPB_W-1:0] BRAKE_K     = 24'd2160000;
    localparam logic [OPB_W-1:0] DIST_DIV    = 24'd2000;
    localparam logic [OPB_W-1:0] MS_PER_S    = 24'd1000;
    localparam logic [10:0]      ACCEL_FULL  = 11'd1200;
    localparam logic [10:0]      BRAKE_FULL  = 11'd1800;
    localparam logic [9:0]       TILT_LIMIT  = 10'd273;
    localparam logic [6:0]       LOCK_MARGIN = 7'd91;
    localparam logic [23:0]      CRUISE_MAX  = 24'd16774215;
    localparam logic [19:0]      TURN_MAX    = 20'd524288;
    localparam logic [16:0]      RATE_MAX    = 17'd65536;
    localparam logic [16:0]      RATE_DFLT   = 17'd8192;
    localparam logic [19:0]      ACC_MAX     = 20'd1048575;

    // Segment codes on the result
    localparam logic [1:0] SEG_ACCEL  = 2'd0;
    localparam logic [1:0] SEG_CRUISE = 2'd1;
    localparam logic [1:0] SEG_BRAKE  = 2'd2;
    localparam logic [1:0] SEG_DONE   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_TURN_ANGLE = 2'd0;
    localparam logic [1:0] REG_TURN_RATE  = 2'd1;

    // Action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

endpackage

>>> design/ytp_math.sv
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide,
// two-bits-a-cycle integer square root. Depends on ytp_pkg.
module ytp_math (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ytp_pkg::math_req_t        req,
    input  logic [ytp_pkg::OPA_W-1:0] opa,
    input  logic [ytp_pkg::OPB_W-1:0] opb,
    output logic                      done,
    output logic [ytp_pkg::OPA_W-1:0] result
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [5:0]                cnt_reg, cnt_next;
    ytp_pkg::math_op_t         op_reg, op_next;
    logic [ytp_pkg::OPA_W-1:0] a_reg, a_next;
    logic [ytp_pkg::OPB_W-1:0] b_reg, b_next;
    logic [ytp_pkg::OPA_W-1:0] acc_reg, acc_next;
    logic [25:0]               rem_reg, rem_next;
    logic [25:0]               rem_sh;
    logic [25:0]               trial;

    assign done   = done_reg;
    assign result = (op_reg == ytp_pkg::MATH_DIV) ? a_reg : acc_reg;

    // One bit (or one root digit) per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        rem_sh    = '0;
        trial     = '0;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            a_next    = opa;
            b_next    = opb;
            acc_next  = '0;
            rem_next  = '0;
            case (req.op)
                ytp_pkg::MATH_MUL:  cnt_next = 6'd24;
                ytp_pkg::MATH_DIV:  cnt_next = 6'd48;
                ytp_pkg::MATH_SQRT: cnt_next = 6'd12;
                default:            cnt_next = 6'd1;
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                ytp_pkg::MATH_MUL:
                begin
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = {a_reg[ytp_pkg::OPA_W-2:0], 1'b0};
                    b_next = {1'b0, b_reg[ytp_pkg::OPB_W-1:1]};
                end
                ytp_pkg::MATH_DIV:
                begin
                    rem_sh = {rem_reg[24:0], a_reg[ytp_pkg::OPA_W-1]};
                    a_next = {a_reg[ytp_pkg::OPA_W-2:0], 1'b0};
                    if (rem_sh >= {2'b00, b_reg})
                    begin
                        rem_next  = rem_sh - {2'b00, b_reg};
                        a_next[0] = 1'b1;
                    end
                    else
                    begin
                        rem_next = rem_sh;
                    end
                end
                ytp_pkg::MATH_SQRT:
                begin
                    rem_sh = {rem_reg[23:0], a_reg[23:22]};
                    a_next = {a_reg[ytp_pkg::OPA_W-1:24], a_reg[21:0], 2'b00};
                    trial  = {acc_reg[23:0], 2'b01};
                    if (rem_sh >= trial)
                    begin
                        rem_next = rem_sh - trial;
                        acc_next = {acc_reg[ytp_pkg::OPA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        acc_next = {acc_reg[ytp_pkg::OPA_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ytp_pkg::MATH_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

endmodule

>>> design/yaw_trapezoid_profile_controller_core.sv
// Yaw trapezoid profile controller: start planning, per-tick profile,
// turn accumulation and position hold. Depends on ytp_pkg and ytp_math.
//
// A start plans the turn through a chain of serial multiplies and divides in
// ytp_math, with square roots for short turns; a tick runs a chain of serial
// multiplies and divides there.
// One item at a time; a finished tick shows its result the cycle after it is taken.
// Reset clears the control state and loads the default turn angle and rate; the spin starts out finished.
module yaw_trapezoid_profile_controller_core (
    input  logic          clk,
    input  logic          rst_n,
    // Input items
    input  logic          s_tvalid,
    output logic          s_tready,
    // tdata: elapsed_ms[23:0], yaw_now[39:24], pos_x_mm[63:40],
    //        pos_y_mm[87:64], vel_x_mms[105:88], vel_y_mms[123:106]
    input  logic [127:0]  s_tdata,
    // tuser: action[0]
    input  logic [0:0]    s_tuser,
    // Result items
    output logic          m_tvalid,
    input  logic          m_tready,
    // tdata: yaw_command[15:0], roll_command[25:16], pitch_command[35:26],
    //        turned_so_far[55:36], segment[57:56]
    output logic [63:0]   m_tdata,
    // Configuration writes
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [20:0]   cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    typedef enum logic [4:0] {
        SP_MUL1, SP_DIV1, SP_SQ1, SP_MUL2, SP_DIV2, SP_SQ2,
        SP_MAD, SP_DAD, SP_MBD, SP_DBD, SP_MCR, SP_DCR,
        SP_MDEN, SP_MSQ, SP_MR, SP_DV, SP_MC, SP_DC, SP_FIN,
        SP_H1, SP_H2, SP_H3, SP_H4
    } step_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    logic signed [20:0] angle_reg, angle_next;
    logic [16:0]        cfg_rate_reg, cfg_rate_next;
    logic [19:0]        size_reg, size_next;
    logic [16:0]        rate_reg, rate_next;
    logic               neg_reg, neg_next;
    logic               fin_reg, fin_next;
    logic [15:0]        start_reg, start_next;
    logic [15:0]        prev_reg, prev_next;
    logic [19:0]        acc_reg, acc_next;
    logic signed [23:0] cx_reg, cx_next;
    logic signed [23:0] cy_reg, cy_next;
    logic [10:0]        accel_reg, accel_next;
    logic [10:0]        brake_reg, brake_next;
    logic [23:0]        cruise_reg, cruise_next;
    logic [19:0]        ad_reg, ad_next;

    logic [23:0]        e_reg, e_next;
    logic [1:0]         seg_reg, seg_next;
    logic               last_reg, last_next;
    logic signed [24:0] ex_reg, ex_next;
    logic signed [24:0] ey_reg, ey_next;
    logic signed [17:0] vx_reg, vx_next;
    logic signed [17:0] vy_reg, vy_next;
    logic [47:0]        x_reg, x_next;
    logic [23:0]        den_reg, den_next;
    logic [19:0]        turned_reg, turned_next;
    logic signed [47:0] pacc_reg, pacc_next;
    logic signed [47:0] racc_reg, racc_next;

    logic               ovalid_reg, ovalid_next;
    logic [15:0]        oyaw_reg, oyaw_next;
    logic signed [9:0]  oroll_reg, oroll_next;
    logic signed [9:0]  opitch_reg, opitch_next;
    logic [19:0]        oturn_reg, oturn_next;
    logic [1:0]         oseg_reg, oseg_next;

    ytp_pkg::math_req_t        mreq;
    logic [ytp_pkg::OPA_W-1:0] opa;
    logic [ytp_pkg::OPB_W-1:0] opb;
    logic                      mdone;
    logic [ytp_pkg::OPA_W-1:0] mres;

    // Input field views
    logic               in_action;
    logic [23:0]        in_elapsed;
    logic [15:0]        in_yaw;
    logic signed [23:0] in_px, in_py;
    logic signed [17:0] in_vx, in_vy;

    // Planning and profile helpers
    logic [20:0]        ang_mag;
    logic [19:0]        a_plan;
    logic [16:0]        r_plan;
    logic               short_turn;
    logic [24:0]        total;
    logic [23:0]        e_sat;
    logic [23:0]        rem_t;
    logic [15:0]        step16;
    logic signed [17:0] delta;
    logic signed [21:0] acc_sum;
    logic [19:0]        acc_upd;
    logic [20:0]        dist_sum;
    logic [47:0]        turned_w;
    logic [19:0]        turned_cap;
    logic               lock_hit;
    logic [24:0]        ex_mag, ey_mag;
    logic [17:0]        vx_mag, vy_mag;
    logic signed [47:0] res_s;
    logic signed [47:0] racc_fin;

    assign in_action  = s_tuser[0];
    assign in_elapsed = s_tdata[23:0];
    assign in_yaw     = s_tdata[39:24];
    assign in_px      = s_tdata[63:40];
    assign in_py      = s_tdata[87:64];
    assign in_vx      = s_tdata[105:88];
    assign in_vy      = s_tdata[123:106];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {6'd0, oseg_reg, oturn_reg, opitch_reg, oroll_reg, oyaw_reg};

    ytp_math u_math (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mreq),
        .opa    (opa),
        .opb    (opb),
        .done   (mdone),
        .result (mres)
    );

    // Heading reached after a given turn from the start heading
    function automatic logic [15:0] heading_at(input logic [15:0] base,
                                               input logic        neg,
                                               input logic [19:0] turned);
        heading_at = neg ? base - turned[15:0] : base + turned[15:0];
    endfunction

    // Round Q16 to nearest, ties away from zero, and clamp the tilt
    function automatic logic signed [9:0] tilt(input logic signed [47:0] raw);
        logic [47:0] mag;
        logic [47:0] q;
        logic [9:0]  qc;
        mag = raw[47] ? 48'(-raw) : 48'(raw);
        q   = (mag + 48'd32768) >> 16;
        qc  = (q > 48'(ytp_pkg::TILT_LIMIT)) ? ytp_pkg::TILT_LIMIT : q[9:0];
        tilt = raw[47] ? $signed(-qc) : $signed(qc);
    endfunction

    // Latched plan values from configuration
    always_comb
    begin
        ang_mag = angle_reg[20] ? 21'(-angle_reg) : 21'(angle_reg);
        a_plan  = (ang_mag > 21'(ytp_pkg::TURN_MAX)) ? ytp_pkg::TURN_MAX : ang_mag[19:0];
        if (cfg_rate_reg == 17'd0)
        begin
            r_plan = ytp_pkg::RATE_DFLT;
        end
        else if (cfg_rate_reg > ytp_pkg::RATE_MAX)
        begin
            r_plan = ytp_pkg::RATE_MAX;
        end
        else
        begin
            r_plan = cfg_rate_reg;
        end
        short_turn = ({1'b0, a_plan, 1'b0} < (22'(r_plan) + {4'd0, r_plan, 1'b0}));
    end

    // Profile timing and turn accumulation views
    always_comb
    begin
        total   = 25'(accel_reg) + 25'(brake_reg) + 25'(cruise_reg);
        e_sat   = (25'(in_elapsed) > total) ? total[23:0] : in_elapsed;
        rem_t   = 24'(total - 25'(e_reg));
        step16  = in_yaw - prev_reg;
        delta   = neg_reg ? -18'($signed(step16)) : 18'($signed(step16));
        acc_sum = $signed({2'b00, acc_reg}) + 22'(delta);
        if (acc_sum < 0)
        begin
            acc_upd = '0;
        end
        else if (acc_sum > $signed({2'b00, ytp_pkg::ACC_MAX}))
        begin
            acc_upd = ytp_pkg::ACC_MAX;
        end
        else
        begin
            acc_upd = acc_sum[19:0];
        end
        dist_sum = 21'(ad_reg) + 21'(mres[19:0]);
        if (seg_reg == ytp_pkg::SEG_BRAKE)
        begin
            turned_w = (x_reg < 48'(size_reg)) ? 48'(size_reg) - x_reg : 48'd0;
        end
        else
        begin
            turned_w = x_reg;
        end
        turned_cap = (turned_w > 48'(size_reg)) ? size_reg : turned_w[19:0];
        lock_hit   = (seg_reg == ytp_pkg::SEG_BRAKE)
                     && ((21'(acc_reg) + 21'(ytp_pkg::LOCK_MARGIN)) >= 21'(size_reg));
        ex_mag  = ex_reg[24] ? 25'(-ex_reg) : 25'(ex_reg);
        ey_mag  = ey_reg[24] ? 25'(-ey_reg) : 25'(ey_reg);
        vx_mag  = vx_reg[17] ? 18'(-vx_reg) : 18'(vx_reg);
        vy_mag  = vy_reg[17] ? 18'(-vy_reg) : 18'(vy_reg);
        res_s   = $signed(mres);
        racc_fin = racc_reg + (vy_reg[17] ? -res_s : res_s);
    end

    // Operand select for the serial unit
    always_comb
    begin
        opa = x_reg;
        opb = 24'(rate_reg);
        case (step_reg)
            SP_MUL1: begin opa = 48'(size_reg);  opb = ytp_pkg::ACCEL_K; end
            SP_MUL2: begin opa = 48'(size_reg);  opb = ytp_pkg::BRAKE_K; end
            SP_MAD:  begin opa = 48'(rate_reg);  opb = 24'(accel_reg); end
            SP_MBD:  begin opa = 48'(rate_reg);  opb = 24'(brake_reg); end
            SP_DAD:  begin opa = x_reg;          opb = ytp_pkg::DIST_DIV; end
            SP_DBD:  begin opa = x_reg;          opb = ytp_pkg::DIST_DIV; end
            SP_MCR:  begin opa = x_reg;          opb = ytp_pkg::MS_PER_S; end
            SP_MDEN:
            begin
                opa = (seg_reg == ytp_pkg::SEG_ACCEL) ? 48'(accel_reg) : 48'(brake_reg);
                opb = ytp_pkg::DIST_DIV;
            end
            SP_MSQ:
            begin
                opa = (seg_reg == ytp_pkg::SEG_ACCEL) ? 48'(e_reg) : 48'(rem_t);
                opb = (seg_reg == ytp_pkg::SEG_ACCEL) ? e_reg : rem_t;
            end
            SP_DV:   begin opa = x_reg;          opb = den_reg; end
            SP_MC:   begin opa = 48'(e_reg - 24'(accel_reg)); opb = 24'(rate_reg); end
            SP_DC:   begin opa = x_reg;          opb = ytp_pkg::MS_PER_S; end
            SP_H1:   begin opa = 48'(ex_mag);    opb = ytp_pkg::KP_Q16; end
            SP_H2:   begin opa = 48'(vx_mag);    opb = ytp_pkg::KV_Q16; end
            SP_H3:   begin opa = 48'(ey_mag);    opb = ytp_pkg::KP_Q16; end
            SP_H4:   begin opa = 48'(vy_mag);    opb = ytp_pkg::KV_Q16; end
            default: begin opa = x_reg;          opb = 24'(rate_reg); end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        angle_next    = angle_reg;
        cfg_rate_next = cfg_rate_reg;
        size_next     = size_reg;
        rate_next     = rate_reg;
        neg_next      = neg_reg;
        fin_next      = fin_reg;
        start_next    = start_reg;
        prev_next     = prev_reg;
        acc_next      = acc_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        accel_next    = accel_reg;
        brake_next    = brake_reg;
        cruise_next   = cruise_reg;
        ad_next       = ad_reg;
        e_next        = e_reg;
        seg_next      = seg_reg;
        last_next     = last_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        x_next        = x_reg;
        den_next      = den_reg;
        turned_next   = turned_reg;
        pacc_next     = pacc_reg;
        racc_next     = racc_reg;
        ovalid_next   = ovalid_reg;
        oyaw_next     = oyaw_reg;
        oroll_next    = oroll_reg;
        opitch_next   = opitch_reg;
        oturn_next    = oturn_reg;
        oseg_next     = oseg_reg;
        mreq.start    = 1'b0;
        mreq.op       = ytp_pkg::MATH_MUL;

        // Take configuration writes
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ytp_pkg::REG_TURN_ANGLE)
            begin
                angle_next = $signed(cfg_data);
            end
            else if (cfg_index == ytp_pkg::REG_TURN_RATE)
            begin
                cfg_rate_next = cfg_data[16:0];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_action == ytp_pkg::ACT_START)
                    begin
                        // Latch references and plan the turn
                        size_next  = a_plan;
                        rate_next  = r_plan;
                        neg_next   = angle_reg[20];
                        start_next = in_yaw;
                        prev_next  = in_yaw;
                        acc_next   = '0;
                        cx_next    = in_px;
                        cy_next    = in_py;
                        fin_next   = (a_plan == 20'd0);
                        if (short_turn)
                        begin
                            step_next = SP_MUL1;
                        end
                        else
                        begin
                            accel_next = ytp_pkg::ACCEL_FULL;
                            brake_next = ytp_pkg::BRAKE_FULL;
                            step_next  = SP_MAD;
                        end
                        state_next = ST_ISSUE;
                    end
                    else if (fin_reg)
                    begin
                        oyaw_next   = heading_at(start_reg, neg_reg, size_reg);
                        oroll_next  = '0;
                        opitch_next = '0;
                        oturn_next  = acc_reg;
                        oseg_next   = ytp_pkg::SEG_DONE;
                        ovalid_next = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        acc_next  = acc_upd;
                        prev_next = in_yaw;
                        e_next    = e_sat;
                        last_next = (25'(e_sat) >= total);
                        ex_next   = 25'(cx_reg) - 25'(in_px);
                        ey_next   = 25'(cy_reg) - 25'(in_py);
                        vx_next   = in_vx;
                        vy_next   = in_vy;
                        x_next    = '0;
                        if (e_sat <= 24'(accel_reg))
                        begin
                            seg_next  = ytp_pkg::SEG_ACCEL;
                            step_next = (accel_reg == 11'd0) ? SP_FIN : SP_MDEN;
                        end
                        else if (25'(e_sat) <= 25'(accel_reg) + 25'(cruise_reg))
                        begin
                            seg_next  = ytp_pkg::SEG_CRUISE;
                            step_next = SP_MC;
                        end
                        else
                        begin
                            seg_next  = ytp_pkg::SEG_BRAKE;
                            step_next = (brake_reg == 11'd0) ? SP_FIN : SP_MDEN;
                        end
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (step_reg == SP_FIN)
                begin
                    // Settle the commanded turn and check for lock
                    if (lock_hit)
                    begin
                        fin_next    = 1'b1;
                        oyaw_next   = heading_at(start_reg, neg_reg, size_reg);
                        oroll_next  = '0;
                        opitch_next = '0;
                        oturn_next  = acc_reg;
                        oseg_next   = ytp_pkg::SEG_DONE;
                        ovalid_next = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        turned_next = turned_cap;
                        step_next   = SP_H1;
                    end
                end
                else
                begin
                    mreq.start = 1'b1;
                    case (step_reg)
                        SP_DIV1, SP_DIV2, SP_DAD, SP_DBD, SP_DCR, SP_DV, SP_DC:
                            mreq.op = ytp_pkg::MATH_DIV;
                        SP_SQ1, SP_SQ2:
                            mreq.op = ytp_pkg::MATH_SQRT;
                        default:
                            mreq.op = ytp_pkg::MATH_MUL;
                    endcase
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (mdone)
                begin
                    state_next = ST_ISSUE;
                    x_next     = mres;
                    case (step_reg)
                        SP_MUL1: step_next = SP_DIV1;
                        SP_DIV1: step_next = SP_SQ1;
                        SP_SQ1:
                        begin
                            accel_next = mres[10:0];
                            step_next  = SP_MUL2;
                        end
                        SP_MUL2: step_next = SP_DIV2;
                        SP_DIV2: step_next = SP_SQ2;
                        SP_SQ2:
                        begin
                            brake_next = mres[10:0];
                            step_next  = SP_MAD;
                        end
                        SP_MAD:  step_next = SP_DAD;
                        SP_DAD:
                        begin
                            ad_next   = mres[19:0];
                            step_next = SP_MBD;
                        end
                        SP_MBD:  step_next = SP_DBD;
                        SP_DBD:
                        begin
                            x_next    = (21'(size_reg) > dist_sum)
                                        ? 48'(21'(size_reg) - dist_sum) : 48'd0;
                            step_next = SP_MCR;
                        end
                        SP_MCR:  step_next = SP_DCR;
                        SP_DCR:
                        begin
                            cruise_next = (mres > 48'(ytp_pkg::CRUISE_MAX))
                                          ? ytp_pkg::CRUISE_MAX : mres[23:0];
                            state_next  = ST_IDLE;
                        end
                        SP_MDEN:
                        begin
                            den_next  = mres[23:0];
                            step_next = SP_MSQ;
                        end
                        SP_MSQ:  step_next = SP_MR;
                        SP_MR:   step_next = SP_DV;
                        SP_DV:   step_next = SP_FIN;
                        SP_MC:   step_next = SP_DC;
                        SP_DC:
                        begin
                            x_next    = 48'(ad_reg) + mres;
                            step_next = SP_FIN;
                        end
                        SP_H1:
                        begin
                            pacc_next = ex_reg[24] ? -res_s : res_s;
                            step_next = SP_H2;
                        end
                        SP_H2:
                        begin
                            pacc_next = pacc_reg - (vx_reg[17] ? -res_s : res_s);
                            step_next = SP_H3;
                        end
                        SP_H3:
                        begin
                            racc_next = ey_reg[24] ? res_s : -res_s;
                            step_next = SP_H4;
                        end
                        SP_H4:
                        begin
                            racc_next   = racc_fin;
                            oyaw_next   = heading_at(start_reg, neg_reg, turned_reg);
                            oroll_next  = tilt(racc_fin);
                            opitch_next = tilt(pacc_reg);
                            oturn_next  = acc_reg;
                            oseg_next   = seg_reg;
                            ovalid_next = 1'b1;
                            fin_next    = last_reg;
                            state_next  = ST_OUT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OUT:
            begin
                // Hold the result until taken
                if (m_tready)
                begin
                    ovalid_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= SP_MUL1;
            angle_reg    <= 21'sd65536;
            cfg_rate_reg <= ytp_pkg::RATE_DFLT;
            size_reg     <= '0;
            rate_reg     <= ytp_pkg::RATE_DFLT;
            neg_reg      <= 1'b0;
            fin_reg      <= 1'b1;
            start_reg    <= '0;
            prev_reg     <= '0;
            acc_reg      <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            accel_reg    <= '0;
            brake_reg    <= '0;
            cruise_reg   <= '0;
            ad_reg       <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            angle_reg    <= angle_next;
            cfg_rate_reg <= cfg_rate_next;
            size_reg     <= size_next;
            rate_reg     <= rate_next;
            neg_reg      <= neg_next;
            fin_reg      <= fin_next;
            start_reg    <= start_next;
            prev_reg     <= prev_next;
            acc_reg      <= acc_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            accel_reg    <= accel_next;
            brake_reg    <= brake_next;
            cruise_reg   <= cruise_next;
            ad_reg       <= ad_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        seg_reg    <= seg_next;
        last_reg   <= last_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        x_reg      <= x_next;
        den_reg    <= den_next;
        turned_reg <= turned_next;
        pacc_reg   <= pacc_next;
        racc_reg   <= racc_next;
        oyaw_reg   <= oyaw_next;
        oroll_reg  <= oroll_next;
        opitch_reg <= opitch_next;
        oturn_reg  <= oturn_next;
        oseg_reg   <= oseg_next;
    end

endmodule

>>> design/ytp_port_checker.sv
// Port-level checks for the yaw trapezoid profile controller core.
// Depends on ytp_pkg; bound to yaw_trapezoid_profile_controller_core.
module ytp_port_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: no input taken while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !m_tvalid)
        else $error("input accepted with a result pending");

    // Locked or finished results carry no tilt
    a_done_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[57:56] == ytp_pkg::SEG_DONE
        |-> m_tdata[25:16] == 10'd0 && m_tdata[35:26] == 10'd0)
        else $error("tilt on a finished result");

    // Tilt stays within the clamp
    a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[25:16]) >= -10'sd273
                  && $signed(m_tdata[25:16]) <= 10'sd273
                  && $signed(m_tdata[35:26]) >= -10'sd273
                  && $signed(m_tdata[35:26]) <= 10'sd273)
        else $error("tilt out of range");

endmodule

bind yaw_trapezoid_profile_controller_core ytp_port_checker u_ytp_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb.sv
// Self-checking bench for yaw_trapezoid_profile_controller_core.
// Predicts each tick result in a scoreboard class; depends on ytp_pkg.
`timescale 1ns / 100ps

module tb;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata = '0;
    logic [0:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [63:0]   m_tdata;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = '0;
    logic [20:0]   cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int ticks_seen = 0;

    yaw_trapezoid_profile_controller_core dut (.*);

    // Spin profile predictor and store of pending tick results
    class spin_scoreboard;
        logic [63:0] angle_reg, rate_reg;
        logic [63:0] start_hd, prev_hd, turned_acc;
        longint      ctr_x, ctr_y;
        logic [63:0] t_acc, t_brk, t_cru, d_acc;
        logic [1:0]  phase;
        logic [63:0] size, rate;
        bit          neg;
        logic [57:0] pending[$];
        int          errors;

        function new();
            angle_reg = 65536; rate_reg = 8192;
            start_hd = 0; prev_hd = 0; turned_acc = 0; ctr_x = 0; ctr_y = 0;
            t_acc = 0; t_brk = 0; t_cru = 0; d_acc = 0; phase = ytp_pkg::SEG_DONE;
            size = 0; rate = 8192; neg = 0; errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [20:0] val);
            if (idx == ytp_pkg::REG_TURN_ANGLE) angle_reg = {43'd0, val};
            else if (idx == ytp_pkg::REG_TURN_RATE) rate_reg = {47'd0, val[16:0]};
        endfunction

        function logic [63:0] root(logic [63:0] n);
            logic [63:0] r, b;
            r = 0; b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin n = n - r - b; r = (r >> 1) + b; end
                else r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [9:0] tilt(longint raw);
            longint q;
            logic [63:0] mag;
            mag = raw < 0 ? -raw : raw;
            q = longint'((mag + 32768) >> 16);
            if (raw < 0) q = -q;
            if (q > 273) q = 273;
            if (q < -273) q = -273;
            return q[9:0];
        endfunction

        function logic [15:0] heading(logic [63:0] t);
            return neg ? start_hd[15:0] - t[15:0] : start_hd[15:0] + t[15:0];
        endfunction

        function void note_item(logic act, logic [123:0] d);
            longint ang, px, py, vx, vy, stp, acc, ex, ey;
            logic [63:0] a, r, dd, rest, tot, e, tr, rem, drop, yaw;
            logic [1:0] seg;
            yaw = {48'd0, d[39:24]};
            px = longint'(signed'(d[63:40])); py = longint'(signed'(d[87:64]));
            vx = longint'(signed'(d[105:88])); vy = longint'(signed'(d[123:106]));
            if (act == ytp_pkg::ACT_START) begin
                ang = longint'(signed'(angle_reg[20:0]));
                a = ang < 0 ? -ang : ang;
                r = rate_reg == 0 ? 8192 : rate_reg;
                if (a > 524288) a = 524288;
                if (r > 65536) r = 65536;
                size = a; rate = r; neg = ang < 0;
                start_hd = yaw; prev_hd = yaw; turned_acc = 0;
                ctr_x = px; ctr_y = py;
                if (2 * a < 3 * r) begin
                    t_acc = root(960000 * a / r); t_brk = root(2160000 * a / r);
                end else begin
                    t_acc = 1200; t_brk = 1800;
                end
                d_acc = r * t_acc / 2000;
                dd = r * t_brk / 2000;
                rest = a > d_acc + dd ? a - d_acc - dd : 0;
                t_cru = rest * 1000 / r;
                if (t_cru > 16774215) t_cru = 16774215;
                phase = a == 0 ? ytp_pkg::SEG_DONE : ytp_pkg::SEG_ACCEL;
                return;
            end
            if (phase == ytp_pkg::SEG_DONE) begin
                pending.push_back({ytp_pkg::SEG_DONE, turned_acc[19:0], 10'd0, 10'd0,
                                   heading(size)});
                return;
            end
            tot = t_acc + t_cru + t_brk;
            e = {40'd0, d[23:0]}; r = rate; a = size;
            if (e > tot) e = tot;
            stp = longint'(signed'(yaw[15:0] - prev_hd[15:0]));
            acc = longint'(turned_acc) + (neg ? -stp : stp);
            if (acc < 0) acc = 0;
            if (acc > 1048575) acc = 1048575;
            turned_acc = acc; prev_hd = yaw;
            if (e <= t_acc) begin
                seg = ytp_pkg::SEG_ACCEL;
                tr = t_acc == 0 ? 0 : r * e * e / (2000 * t_acc);
            end else if (e <= t_acc + t_cru) begin
                seg = ytp_pkg::SEG_CRUISE;
                tr = d_acc + r * (e - t_acc) / 1000;
            end else begin
                seg = ytp_pkg::SEG_BRAKE;
                rem = tot - e;
                drop = t_brk == 0 ? 0 : r * rem * rem / (2000 * t_brk);
                tr = drop < a ? a - drop : 0;
            end
            if (tr > a) tr = a;
            // Lock on the goal once braking gets close enough
            if (seg == ytp_pkg::SEG_BRAKE && longint'(turned_acc) >= longint'(a) - 91) begin
                phase = ytp_pkg::SEG_DONE;
                pending.push_back({ytp_pkg::SEG_DONE, turned_acc[19:0], 10'd0, 10'd0,
                                   heading(a)});
                return;
            end
            ex = ctr_x - px; ey = ctr_y - py;
            pending.push_back({seg, turned_acc[19:0],
                tilt(410139 * ex - 546852 * vx), tilt(-410139 * ey + 546852 * vy),
                heading(tr)});
            phase = e >= tot ? ytp_pkg::SEG_DONE : seg;
        endfunction

        function void check_result(logic [63:0] got);
            logic [57:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result exp none got %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got[15:0] != want[15:0]) begin
                $display("%0t: yaw_command exp %0d got %0d", $time, want[15:0], got[15:0]);
                errors++;
            end
            if (got[25:16] != want[25:16]) begin
                $display("%0t: roll exp %0d got %0d", $time, signed'(want[25:16]),
                         signed'(got[25:16]));
                errors++;
            end
            if (got[35:26] != want[35:26]) begin
                $display("%0t: pitch exp %0d got %0d", $time, signed'(want[35:26]),
                         signed'(got[35:26]));
                errors++;
            end
            if (got[55:36] != want[55:36]) begin
                $display("%0t: turned exp %0d got %0d", $time, want[55:36], got[55:36]);
                errors++;
            end
            if (got[57:56] != want[57:56]) begin
                $display("%0t: segment exp %0d got %0d", $time, want[57:56], got[57:56]);
                errors++;
            end
        endfunction
    endclass

    spin_scoreboard sb = new();

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sample accepted results
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
            ticks_seen++;
        end
    end

    // Randomly stall the result side
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(logic act, logic [123:0] d);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = {4'd0, d};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(act, d);
        items_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Field packing for one input item
    function automatic logic [123:0] pack_in(int el, int yw, int px, int py, int vx, int vy);
        return {vy[17:0], vx[17:0], py[23:0], px[23:0], yw[15:0], el[23:0]};
    endfunction

    task automatic drain();
        int n;
        n = 0;
        while (sb.pending.size() != 0) @(negedge clk);
        // a start leaves no result but keeps the block busy
        while (n < 600)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [20:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_field(output int v, input int w);
        case ($urandom_range(3))
            0: v = 0;
            1: v = -1;
            2: v = $urandom_range(255) - 128;
            default: v = $urandom;
        endcase
        v = v & ((1 << w) - 1);
    endtask

    // One spin: start then a rising sequence of ticks with random content, with stray random items mixed in
    task automatic run_spin(int ticks);
        int el, yw, px, py, vx, vy, step;
        random_field(px, 24); random_field(py, 24);
        yw = $urandom_range(65535);
        send_item(ytp_pkg::ACT_START, pack_in($urandom, yw, px, py, 0, 0));
        el = 0;
        step = $urandom_range(1) ? 30 : $urandom_range(400);
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(19) == 0)
            begin
                send_item($urandom_range(1) ? ytp_pkg::ACT_START : ytp_pkg::ACT_TICK,
                          pack_in($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
                continue;
            end
            el += $urandom_range(2 * step);
            yw += int'((sb.neg ? -1 : 1) * $urandom_range(2 * step) * sb.rate / 1000)
                  + $urandom_range(40) - 20;
            px = int'(($urandom_range(1) ? sb.ctr_x : 0) + $urandom_range(200) - 100);
            py = int'(($urandom_range(1) ? sb.ctr_y : 0) + $urandom_range(200) - 100);
            random_field(vx, 18); random_field(vy, 18);
            if ($urandom_range(7) == 0) begin px = $urandom; py = $urandom; end
            send_item(ytp_pkg::ACT_TICK, pack_in(el, yw, px, py, vx, vy));
        end
    endtask

    initial
    begin
        int angles[6];
        int rates[6];
        angles = '{65536, 21'h100000, 21'h0FFFFF, 0, -16384, 300};
        rates = '{8192, 0, 65536, 1, 131071, 700};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: ticks while finished, extremes, zero turn, config writes
        send_item(ytp_pkg::ACT_TICK, pack_in(0, 0, 0, 0, 0, 0));
        send_item(ytp_pkg::ACT_TICK, {124{1'b1}});
        send_item(ytp_pkg::ACT_START, pack_in(0, 100, -8388608, 8388607, 0, 0));
        send_item(ytp_pkg::ACT_TICK, pack_in(0, 100, 8388607, -8388608, -131072, 131071));
        send_item(ytp_pkg::ACT_TICK, pack_in(600, 4000, -8388608, 8388607, 131071, -131072));
        send_item(ytp_pkg::ACT_TICK, pack_in(1500, 30000, 0, 0, 5, -5));
        send_item(ytp_pkg::ACT_TICK, pack_in(16777215, 65535, 1, 1, 1, 1));
        drain();
        write_cfg(ytp_pkg::REG_TURN_ANGLE, 21'd0);
        write_cfg(ytp_pkg::REG_TURN_RATE, 21'd0);
        send_item(ytp_pkg::ACT_START, pack_in(0, 7, 0, 0, 0, 0));
        send_item(ytp_pkg::ACT_TICK, pack_in(10, 9, 0, 0, 0, 0));
        drain();
        write_cfg(ytp_pkg::REG_TURN_ANGLE, 21'h100000);
        write_cfg(ytp_pkg::REG_TURN_RATE, 21'h1FFFFF);
        send_item(ytp_pkg::ACT_START, pack_in(0, 0, 0, 0, 0, 0));
        send_item(ytp_pkg::ACT_TICK, pack_in(16777215, 0, 0, 0, 0, 0));
        drain();
        write_cfg(ytp_pkg::REG_TURN_RATE, 21'h020000);
        send_item(ytp_pkg::ACT_START, pack_in(0, 0, 0, 0, 0, 0));
        send_item(ytp_pkg::ACT_TICK, pack_in(100, 0, 0, 0, 0, 0));
        drain();

        // Random spins through idle phases and register settings
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 84; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 84; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            drain();
            if (ph < 6)
            begin
                write_cfg(ytp_pkg::REG_TURN_ANGLE, 21'(angles[ph]));
                write_cfg(ytp_pkg::REG_TURN_RATE, 21'(rates[ph]));
            end
            else
            begin
                write_cfg(ytp_pkg::REG_TURN_ANGLE,
                          21'($urandom_range(1) ? $urandom : $urandom_range(20000)));
                write_cfg(ytp_pkg::REG_TURN_RATE,
                          21'($urandom_range(1) ? $urandom : $urandom_range(20000)));
            end
            for (int k = 0; k < 4; k++)
                run_spin($urandom_range(8, 30));
        end
        drain();
        $display("Covered %0d input items and %0d checked results over", items_sent, ticks_seen);
        $display("finished ticks, all segments, locks and several register settings.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("yaw_trapezoid_profile_controller_core regression: pass");
        else
            $display("yaw_trapezoid_profile_controller_core regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("yaw_trapezoid_profile_controller_core regression: fail");
        $finish;
    end
endmodule
